// ===== src/tbof_pkg.sv =====
// Types and constants shared by the touch burst filter modules.
// No dependencies.
`default_nettype none

package tbof_pkg;

   // Sample width and burst shape
   localparam int SAMPLE_BITS  = 12;
   localparam int BURST_LENGTH = 5;
   localparam int KEEP_DEPTH   = BURST_LENGTH - 1;
   localparam int KEEP_IDX_BITS = $clog2(KEEP_DEPTH);
   localparam int COUNT_BITS   = 3;

   // Squared distance and limit widths
   localparam int SQ_BITS     = 2 * SAMPLE_BITS + 1;
   localparam int LIMIT_BITS  = 25;
   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(8000);

   // Averaging sums
   localparam int SUM121_BITS   = SAMPLE_BITS + 2;
   localparam int SUM14641_BITS = SAMPLE_BITS + 4;

   // Command codes
   localparam logic CMD_PEN    = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   typedef struct packed {
      logic                   cmd;
      logic [SAMPLE_BITS-1:0] x_sample;
      logic [SAMPLE_BITS-1:0] y_sample;
      logic                   pen_down;
   } tbof_req_type;

   typedef struct packed {
      logic                   pressure;
      logic [SAMPLE_BITS-1:0] x_pos;
      logic [SAMPLE_BITS-1:0] y_pos;
   } tbof_rsp_type;

   // One finished burst handed from front to back
   typedef struct packed {
      logic [BURST_LENGTH-1:0][SAMPLE_BITS-1:0] xs;
      logic [BURST_LENGTH-1:0][SAMPLE_BITS-1:0] ys;
      logic                                     pen_down;
   } tbof_job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } tbof_q_status_type;

endpackage

`default_nettype wire

// ===== src/tbof_front.sv =====
// Front end: takes request beats, tracks pen/sampling state, gathers bursts.
// Depends on tbof_pkg.
`default_nettype none

module tbof_front
   import tbof_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_accept,
   input  wire tbof_req_type      req_data,
   output logic                   job_push,
   output tbof_job_type           job_data
);

   logic                           sampling_ff, sampling_in;
   logic [COUNT_BITS-1:0]          count_ff, count_in;
   logic [SAMPLE_BITS-1:0]         x_keep_ff [KEEP_DEPTH];
   logic [SAMPLE_BITS-1:0]         y_keep_ff [KEEP_DEPTH];
   logic                           keep_wr;
   logic                           last_sample;

   assign last_sample = (count_ff == COUNT_BITS'(BURST_LENGTH - 1));

   // Pen and burst control
   always_comb begin
      sampling_in = sampling_ff;
      count_in    = count_ff;
      job_push    = 1'b0;
      keep_wr     = 1'b0;
      if (req_accept) begin
         if (req_data.cmd == CMD_PEN) begin
            if (!sampling_ff && req_data.pen_down) begin
               sampling_in = 1'b1;
               count_in    = '0;
            end
         end else if (sampling_ff) begin
            if (last_sample) begin
               job_push = 1'b1;
               count_in = '0;
               if (!req_data.pen_down) begin
                  sampling_in = 1'b0;
               end
            end else begin
               keep_wr  = 1'b1;
               count_in = count_ff + COUNT_BITS'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sampling_ff <= 1'b0;
         count_ff    <= '0;
      end else begin
         sampling_ff <= sampling_in;
         count_ff    <= count_in;
      end
   end

   // Sample store for the first four beats of a burst
   always_ff @(posedge clock) begin
      if (keep_wr) begin
         x_keep_ff[count_ff[KEEP_IDX_BITS-1:0]] <= req_data.x_sample;
         y_keep_ff[count_ff[KEEP_IDX_BITS-1:0]] <= req_data.y_sample;
      end
   end

   // Burst record: stored samples plus the closing beat
   always_comb begin
      for (int i = 0; i < KEEP_DEPTH; i++) begin
         job_data.xs[i] = x_keep_ff[i];
         job_data.ys[i] = y_keep_ff[i];
      end
      job_data.xs[BURST_LENGTH-1] = req_data.x_sample;
      job_data.ys[BURST_LENGTH-1] = req_data.y_sample;
      job_data.pen_down           = req_data.pen_down;
   end

endmodule

`default_nettype wire

// ===== src/tbof_job_queue.sv =====
// Two-entry queue of finished bursts between front and back.
// Depends on tbof_pkg.
`default_nettype none

module tbof_job_queue
   import tbof_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   input  wire tbof_job_type push_data,
   input  wire logic        pop,
   output tbof_job_type     pop_data,
   output tbof_q_status_type status
);

   tbof_job_type entry_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;

   assign status.full  = (count_ff == 2'd2);
   assign status.empty = (count_ff == 2'd0);
   assign pop_data     = entry_ff[rd_ptr_ff];

   // Pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== src/tbof_back.sv =====
// Back end: distance checks, pattern decode, averaging, result register.
// Depends on tbof_pkg.
`default_nettype none

module tbof_back
   import tbof_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [LIMIT_BITS-1:0] distance_limit,
   input  wire tbof_job_type          job_data,
   input  wire tbof_q_status_type     q_status,
   output logic                       job_pop,
   output logic                       rsp_valid,
   output tbof_rsp_type               rsp_data,
   input  wire logic                  rsp_pop
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_DIST  = 2'd1;
   localparam logic [1:0] ST_FLUSH = 2'd2;
   localparam logic [1:0] ST_EVAL  = 2'd3;

   // Triple patterns, oldest triple in the top bit
   localparam logic [2:0] PAT_MID_A  = 3'b010;
   localparam logic [2:0] PAT_MID_B  = 3'b011;
   localparam logic [2:0] PAT_MID_C  = 3'b110;
   localparam logic [2:0] PAT_FULL_A = 3'b101;
   localparam logic [2:0] PAT_FULL_B = 3'b111;

   localparam int PAIRS = BURST_LENGTH - 1;

   logic [1:0]                     state_ff, state_in;
   logic [1:0]                     dist_idx_ff, dist_idx_in;
   logic                           sq_valid_ff, sq_valid_in;
   logic [PAIRS-1:0]               within_ff, within_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   tbof_job_type                   job_ff;
   logic [BURST_LENGTH-1:0][SAMPLE_BITS-1:0] dx_line_ff, dy_line_ff;
   logic [2*SAMPLE_BITS-1:0]       sq_x_ff, sq_y_ff;
   tbof_rsp_type                   rsp_ff, rsp_in;
   logic                           load_job, load_rsp;
   logic [SAMPLE_BITS-1:0]         dx, dy;
   logic [SQ_BITS-1:0]             sq_sum;
   logic                           pair_ok;
   logic [2:0]                     pattern;
   logic                           keep_mid, keep_full, has_result;
   logic [SUM121_BITS-1:0]         x_sum121, y_sum121;
   logic [SUM14641_BITS-1:0]       x_sum14641, y_sum14641;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign job_pop   = load_job;

   // Distance of the pair at the head of the shift lines
   assign dx = (dx_line_ff[0] > dx_line_ff[1]) ? dx_line_ff[0] - dx_line_ff[1]
                                               : dx_line_ff[1] - dx_line_ff[0];
   assign dy = (dy_line_ff[0] > dy_line_ff[1]) ? dy_line_ff[0] - dy_line_ff[1]
                                               : dy_line_ff[1] - dy_line_ff[0];
   assign sq_sum  = SQ_BITS'(sq_x_ff) + SQ_BITS'(sq_y_ff);
   assign pair_ok = (sq_sum <= SQ_BITS'(distance_limit));

   // Pattern decode
   assign pattern = {within_ff[3] & within_ff[2],
                     within_ff[2] & within_ff[1],
                     within_ff[1] & within_ff[0]};

   always_comb begin
      keep_mid  = 1'b0;
      keep_full = 1'b0;
      unique case (pattern) inside
         PAT_MID_A, PAT_MID_B, PAT_MID_C: keep_mid  = 1'b1;
         PAT_FULL_A, PAT_FULL_B:          keep_full = 1'b1;
         default: ;
      endcase
   end

   // Weighted sums: 1-2-1 over samples 1..3, 1-4-6-4-1 over all five
   assign x_sum121 = SUM121_BITS'(job_ff.xs[1]) + (SUM121_BITS'(job_ff.xs[2]) << 1)
                   + SUM121_BITS'(job_ff.xs[3]);
   assign y_sum121 = SUM121_BITS'(job_ff.ys[1]) + (SUM121_BITS'(job_ff.ys[2]) << 1)
                   + SUM121_BITS'(job_ff.ys[3]);
   assign x_sum14641 = SUM14641_BITS'(job_ff.xs[0]) + (SUM14641_BITS'(job_ff.xs[1]) << 2)
                     + (SUM14641_BITS'(job_ff.xs[2]) << 2) + (SUM14641_BITS'(job_ff.xs[2]) << 1)
                     + (SUM14641_BITS'(job_ff.xs[3]) << 2) + SUM14641_BITS'(job_ff.xs[4]);
   assign y_sum14641 = SUM14641_BITS'(job_ff.ys[0]) + (SUM14641_BITS'(job_ff.ys[1]) << 2)
                     + (SUM14641_BITS'(job_ff.ys[2]) << 2) + (SUM14641_BITS'(job_ff.ys[2]) << 1)
                     + (SUM14641_BITS'(job_ff.ys[3]) << 2) + SUM14641_BITS'(job_ff.ys[4]);

   assign has_result = !job_ff.pen_down || keep_mid || keep_full;

   // Result word
   always_comb begin
      rsp_in.pressure = job_ff.pen_down;
      rsp_in.x_pos    = '0;
      rsp_in.y_pos    = '0;
      if (job_ff.pen_down && keep_mid) begin
         rsp_in.x_pos = x_sum121[SUM121_BITS-1:2];
         rsp_in.y_pos = y_sum121[SUM121_BITS-1:2];
      end else if (job_ff.pen_down && keep_full) begin
         rsp_in.x_pos = x_sum14641[SUM14641_BITS-1:4];
         rsp_in.y_pos = y_sum14641[SUM14641_BITS-1:4];
      end
   end

   // Sequencer
   always_comb begin
      state_in    = state_ff;
      dist_idx_in = dist_idx_ff;
      sq_valid_in = (state_ff == ST_DIST);
      within_in   = sq_valid_ff ? {within_ff[PAIRS-2:0], pair_ok} : within_ff;
      load_job    = 1'b0;
      load_rsp    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty) begin
               load_job    = 1'b1;
               dist_idx_in = '0;
               state_in    = ST_DIST;
            end
         end
         ST_DIST: begin
            dist_idx_in = dist_idx_ff + 2'd1;
            if (dist_idx_ff == 2'(PAIRS - 1)) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (!has_result) begin
               state_in = ST_IDLE;
            end else if (!rsp_valid_ff || rsp_pop) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      rsp_valid_in = load_rsp ? 1'b1 : (rsp_pop ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         dist_idx_ff  <= '0;
         sq_valid_ff  <= 1'b0;
         within_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dist_idx_ff  <= dist_idx_in;
         sq_valid_ff  <= sq_valid_in;
         within_ff    <= within_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Burst copy, shift lines and squares
   always_ff @(posedge clock) begin
      if (load_job) begin
         job_ff     <= job_data;
         dx_line_ff <= job_data.xs;
         dy_line_ff <= job_data.ys;
      end else if (state_ff == ST_DIST) begin
         for (int i = 0; i < BURST_LENGTH - 1; i++) begin
            dx_line_ff[i] <= dx_line_ff[i+1];
            dy_line_ff[i] <= dy_line_ff[i+1];
         end
      end
      sq_x_ff <= dx * dx;
      sq_y_ff <= dy * dy;
      if (load_rsp) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/touch_burst_outlier_filter.sv =====
// Touch-panel burst filter: one request queue port in, one result queue port out.
//
// Request beats (req_push/req_full) carry either a pen event (cmd 0) or one
// X/Y sample pair (cmd 1). A pen-down event while idle opens sampling; every
// fifth sample closes a burst. A burst with the pen still down yields a touch
// point (pressure 1) when its distance pattern keeps one; with the pen up it
// yields a pen-lift report (pressure 0, position 0) and sampling stops.
// The front takes one request beat per cycle while req_full is low. A closed
// burst goes into a two-entry burst queue; the back works through each burst
// in turn (load, four squared distances through one pair of 12x12
// multipliers, flush, decode) and takes the next one only once it has
// finished the last. req_full rises only while both queue entries are taken.
// Results (rsp_empty/rsp_pop) sit in one output register; while it is not
// popped the back holds its finished burst and the queue fills behind it.
// csr_wr_en loads csr_wr_data into the distance_limit register.
// Reset (synchronous, active high) clears sampling, queues and the result
// register and sets distance_limit to 8000.
`default_nettype none

module touch_burst_outlier_filter
   import tbof_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_push,
   output logic                       req_full,
   input  wire tbof_req_type          req_data,
   output logic                       rsp_empty,
   input  wire logic                  rsp_pop,
   output tbof_rsp_type               rsp_data,
   input  wire logic                  csr_wr_en,
   input  wire logic [LIMIT_BITS-1:0] csr_wr_data
);

   logic [LIMIT_BITS-1:0] limit_ff, limit_in;
   logic                  req_accept;
   logic                  q_push, q_pop;
   tbof_job_type          q_in_data, q_out_data;
   tbof_q_status_type     q_status;
   logic                  rsp_valid;
   logic                  rsp_accept;

   assign req_full   = q_status.full;
   assign req_accept = req_push && !req_full;
   assign rsp_empty  = !rsp_valid;
   assign rsp_accept = rsp_pop && rsp_valid;

   // Distance limit register
   assign limit_in = csr_wr_en ? csr_wr_data : limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else begin
         limit_ff <= limit_in;
      end
   end

   tbof_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .req_data   (req_data),
      .job_push   (q_push),
      .job_data   (q_in_data)
   );

   tbof_job_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in_data),
      .pop       (q_pop),
      .pop_data  (q_out_data),
      .status    (q_status)
   );

   tbof_back u_back (
      .clock          (clock),
      .reset          (reset),
      .distance_limit (limit_ff),
      .job_data       (q_out_data),
      .q_status       (q_status),
      .job_pop        (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_data       (rsp_data),
      .rsp_pop        (rsp_accept)
   );

   // A pen-lift report always carries a zero position
   a_lift_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_data.pressure) |-> (rsp_data.x_pos == '0 && rsp_data.y_pos == '0))
      else $error("pen-lift report with non-zero position");

   // The front never closes a burst into a full queue
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_status.full)
      else $error("burst pushed into full queue");

   // The back only takes a burst that is there
   a_pop_data: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_status.empty)
      else $error("burst popped from empty queue");

endmodule

`default_nettype wire

// ===== tb/sv/touch_burst_outlier_filter_test.sv =====
// Self-checking testbench for touch_burst_outlier_filter: a directed table, then random
// pen/sample traffic over several distance limits, checked against a burst-filter predictor.
// Depends on tbof_pkg and the touch_burst_outlier_filter RTL only.
module touch_burst_outlier_filter_test
   import tbof_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT    = 400000;
   localparam int SETTLE_CYCLES  = 40;    // room for the back end to finish both queued bursts
   localparam int LONG_HOLD      = 300;
   localparam int PHASE_COUNT    = 6;
   localparam int BEATS_PER_PHASE = 145;
   localparam int LIMIT_TOP      = 33538050;   // 2 * 4095^2
   localparam int LIMIT_ALL_ONES = (1 << LIMIT_BITS) - 1;

   // Distance patterns that keep a point; triple 0-1-2 is the top bit
   localparam logic [2:0] PAT_MID_ONLY  = 3'b010;
   localparam logic [2:0] PAT_MID_LATE  = 3'b011;
   localparam logic [2:0] PAT_EARLY_MID = 3'b110;
   localparam logic [2:0] PAT_ENDS      = 3'b101;
   localparam logic [2:0] PAT_ALL       = 3'b111;

   // Where a table row's result comes from
   localparam bit BY_PREDICTOR = 1'b0;
   localparam bit FIXED        = 1'b1;

   typedef struct {
      tbof_req_type beat;
      bit           typed;
      tbof_rsp_type point;
   } stim_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_push = 1'b0;
   logic                  req_full;
   tbof_req_type          req_data = '0;
   logic                  rsp_empty;
   logic                  rsp_pop = 1'b0;
   tbof_rsp_type          rsp_data;
   logic                  csr_wr_en = 1'b0;
   logic [LIMIT_BITS-1:0] csr_wr_data = '0;

   // Predictor state
   logic [LIMIT_BITS-1:0]  limit_now = LIMIT_RESET;
   bit                     sampling_on = 1'b0;
   int                     held_count = 0;
   logic [SAMPLE_BITS-1:0] burst_x [BURST_LENGTH];
   logic [SAMPLE_BITS-1:0] burst_y [BURST_LENGTH];

   tbof_rsp_type expected_points [$];
   stim_row_type directed_rows [$];
   int           error_count = 0;
   int           cycle_count = 0;
   bit           hold_request = 1'b0;

   // Sender pacing and random burst shape
   int burst_left = 0;
   int centre_x, centre_y, step_size;

   touch_burst_outlier_filter u_top (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_data    (req_data),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #1 clock = ~clock;

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // ---------------------------------------------------------------- predictor
   // squared distance between held samples k and k+1
   function automatic int sq_gap(int k);
      int dx, dy;
      dx = int'(burst_x[k]) - int'(burst_x[k+1]);
      dy = int'(burst_y[k]) - int'(burst_y[k+1]);
      return dx * dx + dy * dy;
   endfunction

   function automatic bit triple_steady(int k);
      return sq_gap(k) <= int'(limit_now) && sq_gap(k + 1) <= int'(limit_now);
   endfunction

   // 1-2-1 over samples 1..3, or 1-4-6-4-1 over all five
   function automatic logic [SAMPLE_BITS-1:0] smooth(input logic [SAMPLE_BITS-1:0] s [BURST_LENGTH],
                                                      input bit wide);
      int acc;
      if (wide)
         acc = (int'(s[0]) + 4 * int'(s[1]) + 6 * int'(s[2]) + 4 * int'(s[3]) + int'(s[4])) >> 4;
      else
         acc = (int'(s[1]) + 2 * int'(s[2]) + int'(s[3])) >> 2;
      return acc[SAMPLE_BITS-1:0];
   endfunction

   // advance the filter by one beat; returns 1 when a point comes out
   function automatic bit step_filter(input tbof_req_type beat, output tbof_rsp_type point);
      logic [2:0] pattern;
      bit         keep;
      bit         wide;
      point = '0;
      keep  = 1'b0;
      wide  = 1'b0;
      if (beat.cmd == CMD_PEN) begin
         if (!sampling_on && beat.pen_down) begin
            sampling_on = 1'b1;
            held_count  = 0;
         end
         return 1'b0;
      end
      if (!sampling_on)
         return 1'b0;
      burst_x[held_count] = beat.x_sample;
      burst_y[held_count] = beat.y_sample;
      held_count++;
      if (held_count < BURST_LENGTH)
         return 1'b0;
      held_count = 0;

      pattern = {triple_steady(0), triple_steady(1), triple_steady(2)};
      case (pattern)
         PAT_MID_ONLY, PAT_MID_LATE, PAT_EARLY_MID: begin
            keep = 1'b1;
         end
         PAT_ENDS, PAT_ALL: begin
            keep = 1'b1;
            wide = 1'b1;
         end
         default: keep = 1'b0;
      endcase

      if (beat.pen_down) begin
         if (!keep)
            return 1'b0;
         point.pressure = 1'b1;
         point.x_pos    = smooth(burst_x, wide);
         point.y_pos    = smooth(burst_y, wide);
         return 1'b1;
      end
      // pen lifted: report at origin and go idle
      sampling_on = 1'b0;
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------- result side
   always @(posedge clock) begin
      tbof_rsp_type want;
      int           pop_left;
      int           stall_left;
      int           hold_left;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         // check the beat taken at this edge
         if (rsp_pop && !rsp_empty) begin
            if (expected_points.size() == 0) begin
               $error("rsp beat with no point expected: %p", rsp_data);
               error_count++;
            end else begin
               want = expected_points.pop_front();
               if (rsp_data.pressure !== want.pressure) begin
                  $error("pressure: expected %0d, got %0d", want.pressure, rsp_data.pressure);
                  error_count++;
               end
               if (rsp_data.x_pos !== want.x_pos) begin
                  $error("x_pos: expected %0d, got %0d", want.x_pos, rsp_data.x_pos);
                  error_count++;
               end
               if (rsp_data.y_pos !== want.y_pos) begin
                  $error("y_pos: expected %0d, got %0d", want.y_pos, rsp_data.y_pos);
                  error_count++;
               end
            end
         end
         // pop pattern: long hold on request, else runs of pops and short stalls
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = LONG_HOLD;
            rsp_pop <= 1'b0;
         end else if (pop_left > 0) begin
            pop_left--;
            rsp_pop <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_pop <= 1'b0;
         end else begin
            pop_left   = $urandom_range(1, 30);
            stall_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            rsp_pop <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------- request side
   // bursts of beats with random gaps between them
   task automatic pace();
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
   endtask

   // offer one beat, wait for it to be taken, then log what it should produce
   task automatic send_beat(input tbof_req_type beat, input bit typed, input tbof_rsp_type fixed);
      tbof_rsp_type point;
      bit           made;
      req_push <= 1'b1;
      req_data <= beat;
      do @(posedge clock); while (req_full);
      made = step_filter(beat, point);
      if (typed)
         expected_points.push_back(fixed);
      else if (made)
         expected_points.push_back(point);
   endtask

   // stop offering and wait for every expected point; optionally let the back end finish
   task automatic drain_points(input bit settle);
      req_push <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (expected_points.size() != 0);
      if (settle)
         repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(input logic [LIMIT_BITS-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      limit_now = value;
   endtask

   function automatic logic [SAMPLE_BITS-1:0] jitter(int centre);
      int v;
      if ($urandom_range(0, 7) == 0)
         return SAMPLE_BITS'($urandom_range(0, 4095));   // outlier
      v = centre + int'($urandom_range(0, 2 * step_size)) - step_size;
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      return v[SAMPLE_BITS-1:0];
   endfunction

   // mostly well-formed traffic: pen-down then samples; some stray beats
   function automatic void make_random_beat(output tbof_req_type beat, output bit effective);
      int pick;
      beat.cmd      = CMD_SAMPLE;
      beat.x_sample = SAMPLE_BITS'($urandom_range(0, 4095));
      beat.y_sample = SAMPLE_BITS'($urandom_range(0, 4095));
      beat.pen_down = 1'($urandom_range(0, 1));
      effective = 1'b0;
      if (!sampling_on) begin
         pick = $urandom_range(0, 9);
         if (pick < 7) begin
            beat.cmd      = CMD_PEN;
            beat.pen_down = 1'b1;
            effective     = 1'b1;
         end else if (pick == 7) begin
            beat.cmd      = CMD_PEN;
            beat.pen_down = 1'b0;
         end
      end else if ($urandom_range(0, 19) == 0) begin
         beat.cmd = CMD_PEN;   // pen bounce mid-burst
      end else begin
         if (held_count == 0) begin
            centre_x = ($urandom_range(0, 5) == 0) ? 4095 * $urandom_range(0, 1)
                                                  : $urandom_range(0, 4095);
            centre_y = $urandom_range(0, 4095);
            case ($urandom_range(0, 5))
               0: step_size = 0;
               1: step_size = 2;
               2: step_size = 30;
               3: step_size = 70;
               4: step_size = 400;
               default: step_size = 4095;
            endcase
         end
         beat.x_sample = jitter(centre_x);
         beat.y_sample = jitter(centre_y);
         if (held_count == BURST_LENGTH - 1)
            beat.pen_down = ($urandom_range(0, 5) != 0);
         effective = 1'b1;
      end
   endfunction

   function automatic void add_row(input logic cmd, input int x, input int y, input logic pen,
                                   input bit typed, input logic pressure, input int xp,
                                   input int yp);
      stim_row_type row;
      row.beat.cmd       = cmd;
      row.beat.x_sample  = SAMPLE_BITS'(x);
      row.beat.y_sample  = SAMPLE_BITS'(y);
      row.beat.pen_down  = pen;
      row.typed          = typed;
      row.point.pressure = pressure;
      row.point.x_pos    = SAMPLE_BITS'(xp);
      row.point.y_pos    = SAMPLE_BITS'(yp);
      directed_rows.push_back(row);
   endfunction

   function automatic logic [LIMIT_BITS-1:0] phase_limit(int phase);
      case (phase)
         1: return '0;
         2: return LIMIT_BITS'(LIMIT_TOP);
         3: return LIMIT_BITS'(1);
         4: return LIMIT_BITS'(LIMIT_ALL_ONES);
         default: return LIMIT_BITS'($urandom_range(2000, 40000));
      endcase
   endfunction

   // ---------------------------------------------------------------- main sequence
   initial begin
      tbof_req_type beat;
      bit           effective;
      int           taken;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      //      cmd         x     y     pen   source        prs   x     y
      // stray beats while idle, then open sampling and bounce the pen
      add_row(CMD_SAMPLE, 1234, 2345, 1'b1, BY_PREDICTOR, 1'b0, 0,    0);
      add_row(CMD_PEN,    0,    0,    1'b0, BY_PREDICTOR, 1'b0, 0,    0);
      add_row(CMD_PEN,    0,    0,    1'b1, BY_PREDICTOR, 1'b0, 0,    0);
      add_row(CMD_PEN,    4095, 4095, 1'b1, BY_PREDICTOR, 1'b0, 0,    0);
      // flat burst at the origin: all steps within limit
      add_row(CMD_SAMPLE, 0,    0,    1'b0, BY_PREDICTOR, 1'b0, 0,    0);
      add_row(CMD_SAMPLE, 0,    0,    1'b1, BY_PREDICTOR, 1'b0, 0,    0);
      add_row(CMD_SAMPLE, 0,    0,    1'b1, BY_PREDICTOR, 1'b0, 0,    0);
      add_row(CMD_SAMPLE, 0,    0,    1'b1, BY_PREDICTOR, 1'b0, 0,    0);
      add_row(CMD_SAMPLE, 0,    0,    1'b1, FIXED,        1'b1, 0,    0);
      // flat burst at full scale
      add_row(CMD_SAMPLE, 4095, 4095, 1'b1, BY_PREDICTOR, 1'b0, 0,    0);
      add_row(CMD_SAMPLE, 4095, 4095, 1'b1, BY_PREDICTOR, 1'b0, 0,    0);
      add_row(CMD_SAMPLE, 4095, 4095, 1'b1, BY_PREDICTOR, 1'b0, 0,    0);
      add_row(CMD_SAMPLE, 4095, 4095, 1'b1, BY_PREDICTOR, 1'b0, 0,    0);
      add_row(CMD_SAMPLE, 4095, 4095, 1'b1, FIXED,        1'b1, 4095, 4095);
      // outliers at both ends: middle triple only, 1-2-1 average
      add_row(CMD_SAMPLE, 0,    4095, 1'b1, BY_PREDICTOR, 1'b0, 0,    0);
      add_row(CMD_SAMPLE, 2000, 2000, 1'b1, BY_PREDICTOR, 1'b0, 0,    0);
      add_row(CMD_SAMPLE, 2000, 2000, 1'b1, BY_PREDICTOR, 1'b0, 0,    0);
      add_row(CMD_SAMPLE, 2000, 2000, 1'b1, BY_PREDICTOR, 1'b0, 0,    0);
      add_row(CMD_SAMPLE, 4095, 0,    1'b1, BY_PREDICTOR, 1'b0, 0,    0);
      // jump in the middle, pen lifted on the last sample: lift report
      add_row(CMD_SAMPLE, 100,  100,  1'b1, BY_PREDICTOR, 1'b0, 0,    0);
      add_row(CMD_SAMPLE, 100,  100,  1'b1, BY_PREDICTOR, 1'b0, 0,    0);
      add_row(CMD_SAMPLE, 100,  100,  1'b1, BY_PREDICTOR, 1'b0, 0,    0);
      add_row(CMD_SAMPLE, 3000, 3000, 1'b1, BY_PREDICTOR, 1'b0, 0,    0);
      add_row(CMD_SAMPLE, 3000, 3000, 1'b0, FIXED,        1'b0, 0,    0);

      foreach (directed_rows[i]) begin
         pace();
         send_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].point);
      end

      // random phases, each under its own distance limit
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         if (phase > 0) begin
            drain_points(1'b1);
            write_limit(phase_limit(phase));
         end
         if (phase == 2 || phase == 5)
            hold_request = 1'b1;   // receiver holds off while beats keep coming
         taken = 0;
         while (taken < BEATS_PER_PHASE) begin
            make_random_beat(beat, effective);
            pace();
            send_beat(beat, BY_PREDICTOR, '0);
            if (effective)
               taken++;
            if (phase == 3 && taken == BEATS_PER_PHASE / 2 && effective)
               drain_points(1'b0);   // sender waits for every point
         end
      end

      drain_points(1'b1);
      if (error_count == 0 && expected_points.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
